// ===== src/lr_pkg.sv =====
package lr_pkg;

  localparam int unsigned COORD_W        = 6;
  localparam int unsigned COORD_BITS_DEF = 6;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } lr_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ===== src/lr_ctrl.sv =====
module lr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  lr_pkg::dp_status_t status_i,
  output lr_pkg::dp_cmd_t    cmd_o
);
  import lr_pkg::*;

  lr_state_e state_q, state_d;
  logic      in_acc, out_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (status_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a taken command always shows its first pixel next cycle
  a_load_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("no pixel after command");

  // the final pixel of a run returns the controller to idle
  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && status_i.last) |=> (state_q == ST_IDLE))
    else $error("run did not end on last pixel");

  // no request is taken while a run is in progress
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request open during run");

endmodule

// ===== src/lr_dp.sv =====
module lr_dp #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lr_pkg::dp_cmd_t            cmd_i,
  output lr_pkg::dp_status_t         status_o,
  input  logic [lr_pkg::COORD_W-1:0] x_start_i,
  input  logic [lr_pkg::COORD_W-1:0] y_start_i,
  input  logic [lr_pkg::COORD_W-1:0] x_end_i,
  input  logic [lr_pkg::COORD_W-1:0] y_end_i,
  output logic [lr_pkg::COORD_W-1:0] pixel_x_o,
  output logic [lr_pkg::COORD_W-1:0] pixel_y_o,
  output logic                       last_pixel_o,
  output logic                       bad_direction_o
);
  import lr_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 2;

  logic [CW-1:0] xs, ys, xe, ye, dx, dy, dmaj, dmin;
  logic          bad, steep, minor_step;
  logic [EW-1:0] err_init;

  logic [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0] steps_q, steps_d, dmaj_q, dmaj_d, dmin_q, dmin_d;
  logic [EW-1:0] err_q, err_d;
  logic          steep_q, steep_d, bad_q, bad_d;

  // command decode
  assign xs       = x_start_i[CW-1:0];
  assign ys       = y_start_i[CW-1:0];
  assign xe       = x_end_i[CW-1:0];
  assign ye       = y_end_i[CW-1:0];
  assign bad      = (xe < xs) || (ye < ys);
  assign dx       = xe - xs;
  assign dy       = ye - ys;
  assign steep    = (dy > dx);
  assign dmaj     = steep ? dy : dx;
  assign dmin     = steep ? dx : dy;
  assign err_init = {1'b0, dmin, 1'b0} - {2'b00, dmaj};

  assign minor_step = ~err_q[EW-1];

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    steps_d = steps_q;
    dmaj_d  = dmaj_q;
    dmin_d  = dmin_q;
    err_d   = err_q;
    steep_d = steep_q;
    bad_d   = bad_q;
    if (cmd_i.load) begin
      cur_x_d = xs;
      cur_y_d = ys;
      bad_d   = bad;
      if (bad) begin
        steps_d = '0;
      end else begin
        steps_d = dmaj;
        dmaj_d  = dmaj;
        dmin_d  = dmin;
        err_d   = err_init;
        steep_d = steep;
      end
    end else if (cmd_i.step) begin
      if (steep_q) begin
        cur_y_d = cur_y_q + 1'b1;
        cur_x_d = cur_x_q + CW'(minor_step);
      end else begin
        cur_x_d = cur_x_q + 1'b1;
        cur_y_d = cur_y_q + CW'(minor_step);
      end
      err_d   = err_q + {1'b0, dmin_q, 1'b0}
                - (minor_step ? {1'b0, dmaj_q, 1'b0} : {EW{1'b0}});
      steps_d = steps_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      steps_q <= '0;
      dmaj_q  <= '0;
      dmin_q  <= '0;
      err_q   <= '0;
      steep_q <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      steps_q <= steps_d;
      dmaj_q  <= dmaj_d;
      dmin_q  <= dmin_d;
      err_q   <= err_d;
      steep_q <= steep_d;
      bad_q   <= bad_d;
    end
  end

  assign status_o.last   = bad_q || (steps_q == '0);
  assign pixel_x_o       = COORD_W'(cur_x_q);
  assign pixel_y_o       = COORD_W'(cur_y_q);
  assign last_pixel_o    = status_o.last;
  assign bad_direction_o = bad_q;

  // each step advances the major axis by exactly one
  a_major_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (steep_q ? (cur_y_q == $past(cur_y_q) + 1'b1)
                            : (cur_x_q == $past(cur_x_q) + 1'b1)))
    else $error("major axis did not advance");

  // a rejected command is a single final result
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && bad) |=> (status_o.last && bad_direction_o))
    else $error("rejected command not single");

  // without a command the position holds
  a_hold_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load || cmd_i.step) |=> ($stable(cur_x_q) && $stable(cur_y_q)))
    else $error("position moved without command");

endmodule

// ===== src/line_rasterizer_core.sv =====
// channel   dir  handshake                 payload
// command   in   in_valid_i / in_stall_o   x_start_i y_start_i x_end_i y_end_i
// pixel     out  out_valid_o / out_stall_i pixel_x_o pixel_y_o last_pixel_o
//                                          bad_direction_o
//
// a command is taken only when idle; its first pixel shows the next cycle
// one pixel per cycle after that while out_stall_i is low; the cycle after the last
// pixel is idle and takes the next command
// the step loop is one update of the error term and position per pixel
// rst_ni clears the controller to idle, asynchronously
// out_stall_i holds the current pixel and stalls the step loop
module line_rasterizer_core #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lr_pkg::COORD_W-1:0] x_start_i,
  input  logic [lr_pkg::COORD_W-1:0] y_start_i,
  input  logic [lr_pkg::COORD_W-1:0] x_end_i,
  input  logic [lr_pkg::COORD_W-1:0] y_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lr_pkg::COORD_W-1:0] pixel_x_o,
  output logic [lr_pkg::COORD_W-1:0] pixel_y_o,
  output logic                       last_pixel_o,
  output logic                       bad_direction_o
);
  import lr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .last_pixel_o    (last_pixel_o),
    .bad_direction_o (bad_direction_o)
  );

endmodule
